### sv/ffha_pkg.sv
`default_nettype none

package ffha_pkg;

    // Widths of the request and response fields.
    localparam int FIELD_W = 14;
    // Width of a stored block header: size in bits 14..3, in-use mark in bit 0.
    localparam int HDR_W   = 15;
    // Width of internal byte offsets, wide enough for a block start plus a size.
    localparam int OFF_W   = 17;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_OOM     = 2'd1;
    localparam logic [1:0] ST_IGNORED = 2'd2;

    localparam logic [FIELD_W-1:0] LIMIT_RESET  = 14'd8192;
    localparam logic [HDR_W-1:0]   HDR_BYTES    = 15'd4;
    localparam logic [HDR_W-1:0]   SMALLEST_BLK = 15'd8;
    localparam logic [HDR_W-1:0]   MIN_SPLIT    = 15'd12;

endpackage

`default_nettype wire

### sv/ffha_if.sv
`default_nettype none

interface ffha_req_if
    import ffha_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic [FIELD_W-1:0] request_bytes;
    logic [FIELD_W-1:0] payload_offset;

    modport source (output valid, output opcode, output request_bytes,
                    output payload_offset, input ready);
    modport sink   (input valid, input opcode, input request_bytes,
                    input payload_offset, output ready);
endinterface

interface ffha_rsp_if
    import ffha_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [FIELD_W-1:0] result_offset;
    logic [FIELD_W-1:0] usable_bytes;

    modport source (output valid, output status, output result_offset,
                    output usable_bytes, input ready);
    modport sink   (input valid, input status, input result_offset,
                    input usable_bytes, output ready);
endinterface

`default_nettype wire

### sv/ffha_ram.sv
`default_nettype none

module ffha_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### sv/first_fit_heap_allocator.sv
// Channel  Role    Handshake      Payload
// req      sink    valid/ready    opcode, request_bytes, payload_offset
// rsp      source  valid/ready    status, result_offset, usable_bytes
// cfg      write   heap_limit_we  heap_limit_wdata (14 bits)
//
// Each request is served by a small sequencer around one header RAM with a
// registered read, so the headers are visited one after another. An
// allocation walks the headers from offset zero, grows the heap when no free
// block fits, claims a block and splits off a large enough remainder; a free
// clears the in-use mark and merges the free blocks that follow; a query
// reads one header, and a refused request goes straight to the response.
// Reset clears the heap top and the response valid and sets the limit to 8192;
// the header store is not cleared. A new request is taken only while the
// sequencer is idle, and a finished response waits in the output register,
// holding the sequencer in its response state while that register is full.
`default_nettype none

module first_fit_heap_allocator
    import ffha_pkg::*;
#(
    parameter int HEAP_BYTES = 8192
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    ffha_req_if.sink                req,
    ffha_rsp_if.source              rsp,
    input  wire logic               heap_limit_we,
    input  wire logic [FIELD_W-1:0] heap_limit_wdata
);

    // One header slot per eight bytes of heap.
    localparam int SLOTS  = HEAP_BYTES / 8;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam logic [31:0] HEAP_LIM32 = 32'(HEAP_BYTES);
    // The largest limit that the heap size itself allows, held in field width.
    localparam logic [FIELD_W-1:0] HEAP_CAP =
        FIELD_W'((HEAP_BYTES < 16384) ? HEAP_BYTES : 16383);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_WALK  = 9'b000000010,
        S_GROW  = 9'b000000100,
        S_CLAIM = 9'b000001000,
        S_SPLIT = 9'b000010000,
        S_FREE  = 9'b000100000,
        S_MERGE = 9'b001000000,
        S_QUERY = 9'b010000000,
        S_RESP  = 9'b100000000
    } state_t;

    function automatic logic [SLOT_W-1:0] slot_of(input logic [OFF_W-1:0] addr);
        return SLOT_W'(addr >> 3);
    endfunction

    // Control state.
    state_t             state_reg, state_next;
    logic [FIELD_W-1:0] heap_top_reg, heap_top_next;
    logic [FIELD_W-1:0] limit_reg, limit_next;
    logic               out_valid_reg, out_valid_next;

    // Working registers of the current request.
    logic [OFF_W-1:0]   blk_reg, blk_next;
    logic [HDR_W-1:0]   need_reg, need_next;
    logic [HDR_W-1:0]   grow_reg, grow_next;
    logic [HDR_W-1:0]   hdr_reg, hdr_next;
    logic [OFF_W-1:0]   size_reg, size_next;
    logic [1:0]         res_status_reg, res_status_next;
    logic [FIELD_W-1:0] res_offset_reg, res_offset_next;
    logic [FIELD_W-1:0] res_usable_reg, res_usable_next;

    // Output register.
    logic [1:0]         out_status_reg, out_status_next;
    logic [FIELD_W-1:0] out_offset_reg, out_offset_next;
    logic [FIELD_W-1:0] out_usable_reg, out_usable_next;

    // Header RAM ports.
    logic               ram_wr_en;
    logic [SLOT_W-1:0]  ram_wr_addr;
    logic [HDR_W-1:0]   ram_wr_data;
    logic               ram_rd_en;
    logic [SLOT_W-1:0]  ram_rd_addr;
    logic [HDR_W-1:0]   ram_rd_data;

    ffha_ram #(
        .WIDTH (HDR_W),
        .DEPTH (SLOTS)
    ) u_hdr_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Request decode: the block need is the request plus the header, rounded
    // up to eight bytes; a request of zero counts as one byte.
    logic [FIELD_W-1:0] req_n;
    logic [HDR_W-1:0]   need_sum;
    logic [HDR_W-1:0]   need_raw;
    logic [HDR_W-1:0]   need_dec;
    logic [HDR_W-1:0]   grow_sum;
    logic [FIELD_W-1:0] hdr_of_req;
    logic               req_hdr_ok;

    assign req_n      = (req.request_bytes == '0) ? FIELD_W'(1) : req.request_bytes;
    assign need_sum   = HDR_W'(req_n) + HDR_BYTES + HDR_W'(7);
    assign need_raw   = {need_sum[HDR_W-1:3], 3'b000};
    assign need_dec   = (need_raw < SMALLEST_BLK) ? SMALLEST_BLK : need_raw;
    assign grow_sum   = need_dec + HDR_W'(63);
    assign hdr_of_req = req.payload_offset - FIELD_W'(HDR_BYTES);
    // A payload offset is usable only if its header sits on a slot boundary
    // inside the heap; null and offsets below the header size are refused.
    assign req_hdr_ok = (req.payload_offset >= FIELD_W'(HDR_BYTES))
                     && (hdr_of_req[2:0] == 3'b000)
                     && (hdr_of_req < heap_top_reg);

    // Header fields of the word just read.
    logic [HDR_W-1:0]   rd_size;
    logic               rd_inuse;
    logic [OFF_W-1:0]   walk_next;
    logic [OFF_W-1:0]   merge_size;
    logic [OFF_W-1:0]   merge_next;
    logic [OFF_W-1:0]   free_next;

    assign rd_size    = {ram_rd_data[HDR_W-1:3], 3'b000};
    assign rd_inuse   = ram_rd_data[0];
    assign walk_next  = blk_reg + OFF_W'(rd_size);
    assign free_next  = blk_reg + OFF_W'(rd_size);
    assign merge_size = size_reg + OFF_W'(rd_size);
    assign merge_next = blk_reg + merge_size;

    // Growth and split arithmetic.
    logic [FIELD_W-1:0] limit_eff;
    logic [FIELD_W+1:0] grow_top;
    logic [HDR_W-1:0]   claim_size;
    logic [HDR_W-1:0]   claim_rem;
    logic [OFF_W-1:0]   split_addr;
    logic [FIELD_W-1:0] claim_offset;

    assign limit_eff    = (limit_reg < HEAP_CAP) ? limit_reg : HEAP_CAP;
    assign grow_top     = (FIELD_W+2)'(heap_top_reg) + (FIELD_W+2)'(grow_reg);
    assign claim_size   = {hdr_reg[HDR_W-1:3], 3'b000};
    assign claim_rem    = claim_size - need_reg;
    assign split_addr   = blk_reg + OFF_W'(need_reg);
    assign claim_offset = FIELD_W'(blk_reg + OFF_W'(HDR_BYTES));

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.result_offset = out_offset_reg;
    assign rsp.usable_bytes  = out_usable_reg;

    always_comb
    begin
        state_next      = state_reg;
        heap_top_next   = heap_top_reg;
        limit_next      = heap_limit_we ? heap_limit_wdata : limit_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        blk_next        = blk_reg;
        need_next       = need_reg;
        grow_next       = grow_reg;
        hdr_next        = hdr_reg;
        size_next       = size_reg;
        res_status_next = res_status_reg;
        res_offset_next = res_offset_reg;
        res_usable_next = res_usable_reg;
        out_status_next = out_status_reg;
        out_offset_next = out_offset_reg;
        out_usable_next = out_usable_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = slot_of(blk_reg);
        ram_wr_data     = hdr_reg;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = slot_of(blk_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    res_status_next = ST_IGNORED;
                    res_offset_next = '0;
                    res_usable_next = '0;
                    need_next       = need_dec;
                    grow_next       = {grow_sum[HDR_W-1:6], 6'b000000};
                    case (req.opcode)
                        OP_ALLOC:
                        begin
                            blk_next = '0;
                            if (heap_top_reg == '0)
                            begin
                                state_next = S_GROW;
                            end
                            else
                            begin
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = '0;
                                state_next  = S_WALK;
                            end
                        end
                        OP_FREE, OP_QUERY:
                        begin
                            blk_next = OFF_W'(hdr_of_req);
                            if (req_hdr_ok)
                            begin
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = slot_of(OFF_W'(hdr_of_req));
                                state_next  = (req.opcode == OP_FREE) ? S_FREE : S_QUERY;
                            end
                            else
                            begin
                                state_next = S_RESP;
                            end
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end

            S_WALK:
            begin
                // First fit: take the first free block that holds the need.
                // A zero-size header ends the walk early.
                if (!rd_inuse && (rd_size >= need_reg))
                begin
                    hdr_next   = ram_rd_data;
                    state_next = S_CLAIM;
                end
                else if ((rd_size == '0) || (walk_next >= OFF_W'(heap_top_reg)))
                begin
                    state_next = S_GROW;
                end
                else
                begin
                    blk_next    = walk_next;
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = slot_of(walk_next);
                end
            end

            S_GROW:
            begin
                if (grow_top > (FIELD_W+2)'(limit_eff))
                begin
                    res_status_next = ST_OOM;
                    state_next      = S_RESP;
                end
                else
                begin
                    blk_next      = OFF_W'(heap_top_reg);
                    heap_top_next = FIELD_W'(grow_top);
                    hdr_next      = grow_reg;
                    state_next    = S_CLAIM;
                end
            end

            S_CLAIM:
            begin
                res_status_next = ST_DONE;
                res_offset_next = claim_offset;
                if (claim_rem >= MIN_SPLIT)
                begin
                    // The remainder becomes a free block of its own; a header
                    // that would fall past the store is dropped.
                    ram_wr_en   = (32'(split_addr) < HEAP_LIM32);
                    ram_wr_addr = slot_of(split_addr);
                    ram_wr_data = claim_rem;
                    state_next  = S_SPLIT;
                end
                else
                begin
                    ram_wr_en   = 1'b1;
                    ram_wr_data = hdr_reg | HDR_W'(1);
                    state_next  = S_RESP;
                end
            end

            S_SPLIT:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_data = need_reg | HDR_W'(1);
                state_next  = S_RESP;
            end

            S_FREE:
            begin
                if (!rd_inuse)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    res_status_next = ST_DONE;
                    size_next       = OFF_W'(rd_size);
                    ram_wr_en       = 1'b1;
                    ram_wr_data     = rd_size;
                    if (free_next < OFF_W'(heap_top_reg))
                    begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = slot_of(free_next);
                        state_next  = S_MERGE;
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
            end

            S_MERGE:
            begin
                // Absorb following free blocks until one in use, a zero-size
                // header or the heap top is met.
                if (rd_inuse || (rd_size == '0))
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    size_next   = merge_size;
                    ram_wr_en   = 1'b1;
                    ram_wr_data = merge_size[HDR_W-1:0];
                    if (merge_next < OFF_W'(heap_top_reg))
                    begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = slot_of(merge_next);
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
            end

            S_QUERY:
            begin
                res_status_next = ST_DONE;
                res_usable_next = (rd_size >= HDR_BYTES) ? FIELD_W'(rd_size - HDR_BYTES)
                                                         : '0;
                state_next      = S_RESP;
            end

            S_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_offset_next = res_offset_reg;
                    out_usable_next = res_usable_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            heap_top_reg  <= '0;
            limit_reg     <= LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            heap_top_reg  <= heap_top_next;
            limit_reg     <= limit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg        <= blk_next;
        need_reg       <= need_next;
        grow_reg       <= grow_next;
        hdr_reg        <= hdr_next;
        size_reg       <= size_next;
        res_status_reg <= res_status_next;
        res_offset_reg <= res_offset_next;
        res_usable_reg <= res_usable_next;
        out_status_reg <= out_status_next;
        out_offset_reg <= out_offset_next;
        out_usable_reg <= out_usable_next;
    end

endmodule

`default_nettype wire
